[rtl/ucs2u8_pkg.sv]
// ----------------------------------------------------------------------------
// ucs2u8_pkg
// shared types and constants for the ucs-2 / utf-8 transcoder
// ----------------------------------------------------------------------------
`default_nettype none

package ucs2u8_pkg;

  localparam int UNIT_W      = 16;
  localparam int COUNT_WIDTH = 16;
  // the count register never needs more than 16 bits, the saturation point caps it
  localparam int CNT_W       = (COUNT_WIDTH < 16) ? COUNT_WIDTH : 16;
  localparam int MAX_RES     = 3;

  localparam logic [UNIT_W-1:0] LIM_ONE_BYTE = 16'h0080;
  localparam logic [UNIT_W-1:0] LIM_TWO_BYTE = 16'h0800;
  localparam logic [7:0]        LEAD_TWO     = 8'hC0;
  localparam logic [7:0]        LEAD_THREE   = 8'hE0;
  localparam logic [7:0]        CONT_MARK    = 8'h80;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_t;

  // decoder / counter state carried from word to word
  typedef struct packed {
    logic [1:0]       pending;
    logic [UNIT_W-1:0] partial;
    logic [CNT_W-1:0]  count;
  } conv_state_t;

  // everything one input word produces
  typedef struct packed {
    logic [1:0]                     num;
    logic [MAX_RES-1:0][UNIT_W-1:0] units;
    logic                           is_end;
    logic                           broken;
    logic [CNT_W-1:0]               count;
  } conv_res_t;

endpackage

`default_nettype wire

[rtl/ucs2u8_if.sv]
// ----------------------------------------------------------------------------
// ucs2u8_if
// valid/ready channels for input words and result words
// ----------------------------------------------------------------------------
`default_nettype none

interface ucs2u8_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] in_unit;

  modport source (output valid, output in_unit, input ready);
  modport sink (input valid, input in_unit, output ready);
endinterface

interface ucs2u8_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_unit;
  logic        out_last;
  logic        string_end;
  logic [15:0] unit_count;
  logic        broken_char;

  modport source (
    output valid, output out_unit, output out_last, output string_end,
    output unit_count, output broken_char, input ready
  );
  modport sink (
    input valid, input out_unit, input out_last, input string_end,
    input unit_count, input broken_char, output ready
  );
endinterface

`default_nettype wire

[rtl/ucs2u8_conv.sv]
// ----------------------------------------------------------------------------
// ucs2u8_conv
// single-pass conversion of one word into up to three results and next state
// ----------------------------------------------------------------------------
`default_nettype none

module ucs2u8_conv
  import ucs2u8_pkg::*;
(
  input  var dir_t              dir,
  input  var logic [UNIT_W-1:0] unit,
  input  var conv_state_t       st,
  output conv_res_t             res,
  output conv_state_t           st_next
);

  always_comb begin
    logic [7:0]       b;
    logic [CNT_W:0]   sum;
    b       = unit[7:0];
    res     = '0;
    st_next = st;
    if (dir == DIR_ENCODE) begin
      if (unit == '0) begin
        res.num    = 2'd1;
        res.is_end = 1'b1;
        res.count  = st.count;
      end else if (unit < LIM_ONE_BYTE) begin
        res.num      = 2'd1;
        res.units[0] = unit;
      end else if (unit < LIM_TWO_BYTE) begin
        res.num      = 2'd2;
        res.units[0] = {8'h00, LEAD_TWO | {3'b000, unit[10:6]}};
        res.units[1] = {8'h00, CONT_MARK | {2'b00, unit[5:0]}};
      end else begin
        res.num      = 2'd3;
        res.units[0] = {8'h00, LEAD_THREE | {4'h0, unit[15:12]}};
        res.units[1] = {8'h00, CONT_MARK | {2'b00, unit[11:6]}};
        res.units[2] = {8'h00, CONT_MARK | {2'b00, unit[5:0]}};
      end
    end else if (st.pending == 2'd0) begin
      if (b == 8'h00) begin
        res.num    = 2'd1;
        res.is_end = 1'b1;
        res.count  = st.count;
      end else if (b < CONT_MARK) begin
        res.num      = 2'd1;
        res.units[0] = {8'h00, b};
      end else if (b < LEAD_THREE) begin
        st_next.partial = {5'b0, b[4:0], 6'b0};
        st_next.pending = 2'd1;
      end else begin
        st_next.partial = {b[3:0], 12'b0};
        st_next.pending = 2'd2;
      end
    end else if (b == 8'h00) begin
      // string cut inside a multibyte character
      res.num    = 2'd1;
      res.is_end = 1'b1;
      res.broken = 1'b1;
      res.count  = st.count;
    end else if (st.pending == 2'd2) begin
      st_next.partial = st.partial | {4'b0, b[5:0], 6'b0};
      st_next.pending = 2'd1;
    end else begin
      res.num         = 2'd1;
      res.units[0]    = st.partial | {10'b0, b[5:0]};
      st_next.pending = 2'd0;
      st_next.partial = '0;
    end

    // saturating unit count, restarted by a terminator
    sum = {1'b0, st.count} + (CNT_W+1)'(res.num);
    if (res.is_end) begin
      st_next = '0;
    end else if (sum[CNT_W]) begin
      st_next.count = '1;
    end else begin
      st_next.count = sum[CNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

[rtl/ucs2_utf8_transcoder.sv]
// ----------------------------------------------------------------------------
// ucs2_utf8_transcoder
// zero-terminated string converter between ucs-2 units and utf-8 bytes
// ----------------------------------------------------------------------------
// Words enter on the units channel and results leave on the results channel,
// both valid/ready. cfg_data selects encode (0, ucs-2 in, utf-8 bytes out) or
// decode (1, utf-8 bytes in the low eight bits, ucs-2 out); writing it also
// restarts the string. A word passes an input register, is converted in one
// pass into all of its results, and those sit in a result buffer that drains
// one result per cycle while the results channel is ready. The result port
// sets the rate: a word holds the buffer until all of its results are taken,
// two for an encoded unit of 0x80..0x7ff and three for one of 0x800 and up;
// decode lead and middle bytes yield nothing. A zero word (when decoding, a
// zero low byte) ends the string with a terminator that carries the
// saturating unit count; broken_char marks a string cut inside a multibyte
// character. The next word is taken while the last result of the previous
// one waits on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module ucs2_utf8_transcoder
  import ucs2u8_pkg::*;
(
  input  var logic      clk,
  input  var logic      rst,
  input  var logic      cfg_we,
  input  var logic      cfg_data,
  ucs2u8_in_if.sink     units,
  ucs2u8_out_if.source  results
);

  // configuration and carried state
  dir_t        direction;
  conv_state_t st;
  conv_state_t st_next;

  // input register
  logic              s1_valid;
  logic [UNIT_W-1:0] s1_unit;

  // result buffer, buf_num of zero means empty
  logic [1:0]                     buf_num;
  logic [1:0]                     buf_idx;
  logic [MAX_RES-1:0][UNIT_W-1:0] buf_units;
  logic                           buf_end;
  logic                           buf_broken;
  logic [CNT_W-1:0]               buf_count;

  conv_res_t res;

  logic buf_last;
  logic buf_free;
  logic s1_adv;

  ucs2u8_conv u_conv (
    .dir     (direction),
    .unit    (s1_unit),
    .st      (st),
    .res     (res),
    .st_next (st_next)
  );

  // buffer frees up once its last result is taken
  assign buf_last = (buf_num != 2'd0) && (buf_idx == buf_num - 2'd1);
  assign buf_free = (buf_num == 2'd0) || (buf_last && results.ready);
  assign s1_adv   = s1_valid && buf_free;

  assign units.ready = !s1_valid || buf_free;

  assign results.valid       = (buf_num != 2'd0);
  assign results.out_unit    = buf_units[buf_idx];
  assign results.out_last    = buf_last;
  assign results.string_end  = buf_end;
  assign results.unit_count  = 16'(buf_count);
  assign results.broken_char = buf_broken;

  // control: direction, string state, occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_ENCODE;
      st        <= '0;
      s1_valid  <= 1'b0;
      buf_num   <= 2'd0;
      buf_idx   <= 2'd0;
    end else begin
      if (units.valid && units.ready) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        buf_num <= res.num;
        buf_idx <= 2'd0;
      end else if (results.valid && results.ready) begin
        if (buf_last) begin
          buf_num <= 2'd0;
        end else begin
          buf_idx <= buf_idx + 2'd1;
        end
      end
      // a direction write starts a new string
      if (cfg_we) begin
        direction <= dir_t'(cfg_data);
        st        <= '0;
      end else if (s1_adv) begin
        st <= st_next;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (units.valid && units.ready) begin
      s1_unit <= units.in_unit;
    end
    if (s1_adv) begin
      buf_units  <= res.units;
      buf_end    <= res.is_end;
      buf_broken <= res.broken;
      buf_count  <= res.count;
    end
  end

  // a terminator is always the only result of its word
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.string_end |-> results.out_last)
    else $error("terminator not marked last");

  // read pointer stays inside the filled part of the buffer
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> buf_idx < buf_num)
    else $error("result index beyond buffer fill");

  // no partial character bits without an open character
  a_partial_clear: assert property (@(posedge clk) disable iff (rst)
    st.pending == 2'd0 |-> st.partial == '0)
    else $error("partial code left without pending bytes");

  // a terminator leaving the converter restarts the string state
  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    s1_adv && res.is_end && !cfg_we |=> st == '0)
    else $error("string state not cleared after terminator");

endmodule

`default_nettype wire

[verif/ucs2u8_checker.sv]
// ----------------------------------------------------------------------------
// ucs2u8_checker
// watches both channels of the transcoder, predicts and compares each result
// ----------------------------------------------------------------------------
// Keeps its own copy of the direction, the decoder state and the unit tally.
// It follows the register writes and predicts every result word of each
// accepted input word. Each accepted result word is compared with the oldest
// prediction. The count of mismatches and the number of result words still
// due go to the testbench top.
// ----------------------------------------------------------------------------

module ucs2u8_checker
  import ucs2u8_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   cfg_we,
  input  logic   cfg_data,
  ucs2u8_in_if   units,
  ucs2u8_out_if  results,
  output int     mismatches,
  output int     results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TALLY_MAX = (COUNT_WIDTH >= 16) ? 65535 : (1 << COUNT_WIDTH) - 1;
  localparam int PRINT_MAX = 30;

  typedef struct packed {
    logic [15:0] code;
    logic        last;
    logic        str_end;
    logic [15:0] count;
    logic        broken;
  } conv_word_t;

  conv_word_t  due_q[$];
  dir_t        dir;
  logic [1:0]  wait_bytes;
  logic [15:0] partial_code;
  int          tally;

  initial begin
    mismatches  = 0;
    results_due = 0;
  end

  function automatic void clear_string();
    wait_bytes   = '0;
    partial_code = '0;
    tally        = 0;
  endfunction

  function automatic void expect_code(logic [15:0] code, logic last);
    due_q.push_back('{code: code, last: last, str_end: 1'b0, count: '0, broken: 1'b0});
    if (tally < TALLY_MAX) tally++;
  endfunction

  function automatic void expect_terminator(logic broken);
    due_q.push_back('{code: '0, last: 1'b1, str_end: 1'b1, count: 16'(tally),
                      broken: broken});
    clear_string();
  endfunction

  function automatic void predict_conversion(logic [15:0] w);
    logic [7:0] b;
    b = w[7:0];
    if (dir == DIR_ENCODE) begin
      if (w == '0) expect_terminator(1'b0);
      else if (w < LIM_ONE_BYTE) expect_code(w, 1'b1);
      else if (w < LIM_TWO_BYTE) begin
        expect_code({8'h00, LEAD_TWO | {3'b000, w[10:6]}}, 1'b0);
        expect_code({8'h00, CONT_MARK | {2'b00, w[5:0]}}, 1'b1);
      end else begin
        expect_code({8'h00, LEAD_THREE | {4'h0, w[15:12]}}, 1'b0);
        expect_code({8'h00, CONT_MARK | {2'b00, w[11:6]}}, 1'b0);
        expect_code({8'h00, CONT_MARK | {2'b00, w[5:0]}}, 1'b1);
      end
    end else if (wait_bytes == 2'd0) begin
      // lead position, high byte of the word is don't-care
      if (b == 8'h00) expect_terminator(1'b0);
      else if (b < CONT_MARK) expect_code({8'h00, b}, 1'b1);
      else if (b < LEAD_THREE) begin
        partial_code = {5'b0, b[4:0], 6'b0};
        wait_bytes   = 2'd1;
      end else begin
        partial_code = {b[3:0], 12'h000};
        wait_bytes   = 2'd2;
      end
    end else if (b == 8'h00) begin
      expect_terminator(1'b1);
    end else if (wait_bytes == 2'd2) begin
      partial_code = partial_code | {4'h0, b[5:0], 6'b0};
      wait_bytes   = 2'd1;
    end else begin
      expect_code(partial_code | {10'b0, b[5:0]}, 1'b1);
      wait_bytes   = 2'd0;
      partial_code = '0;
    end
  endfunction

  function automatic void check_result(conv_word_t got);
    conv_word_t want;
    if (due_q.size() == 0) begin
      mismatches++;
      if (mismatches <= PRINT_MAX)
        $display("%0t: unexpected result word unit %h last %b end %b count %0d %s %b",
                 $time, got.code, got.last, got.str_end, got.count, "broken",
                 got.broken);
      return;
    end
    want = due_q.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= PRINT_MAX) begin
        $display("%0t: expected unit %h last %b end %b count %0d broken %b,",
                 $time, want.code, want.last, want.str_end, want.count, want.broken);
        $display("%0t:      got unit %h last %b end %b count %0d broken %b",
                 $time, got.code, got.last, got.str_end, got.count, got.broken);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      dir = DIR_ENCODE;
      clear_string();
      due_q.delete();
    end else begin
      if (results.valid && results.ready)
        check_result('{code: results.out_unit, last: results.out_last,
                       str_end: results.string_end, count: results.unit_count,
                       broken: results.broken_char});
      if (cfg_we) begin
        dir = dir_t'(cfg_data);
        clear_string();
      end
      if (units.valid && units.ready) predict_conversion(units.in_unit);
    end
    results_due = due_q.size();
  end

endmodule

[verif/tb_ucs2_utf8_transcoder.sv]
// ----------------------------------------------------------------------------
// tb_ucs2_utf8_transcoder
// stimulus and verdict for the ucs-2 / utf-8 transcoder
// ----------------------------------------------------------------------------
// Drives words into the transcoder in both directions with random gaps on
// the input side and random stalls on the result side. A directed part hits
// the range edges, the cut-off characters and the register write in the
// middle of a character. Then random bursts follow, mostly well-formed utf-8
// when decoding. A checker beside the block does all the prediction and
// comparison.
// ----------------------------------------------------------------------------

module tb_ucs2_utf8_transcoder;
  import ucs2u8_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BURST_WORDS = 40;
  localparam int DRAIN_GUARD = 200000;

  // encode: empty string, then each range edge
  localparam logic [15:0] ENC_CASES [8] = '{
    16'h0000, 16'h0001, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF, 16'h0000
  };

  // decode: ascii with high bits set, two- and three-byte characters including
  // the 0x80..0xbf and 0xf0..0xff leads, a zero with high bits, then strings
  // cut off after a two-byte lead and inside a three-byte character
  localparam logic [15:0] DEC_CASES [20] = '{
    16'h0041, 16'hFF41, 16'h00C3, 16'h00A9, 16'h0080, 16'h00BF, 16'h00DF, 16'h00BF,
    16'h00E2, 16'h0082, 16'h00AC, 16'h00FF, 16'h00FF, 16'h00FF, 16'hAB00,
    16'h00C3, 16'h5A00, 16'h00E2, 16'h0082, 16'h0000
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_data;
  logic no_gaps;
  int   out_stall;
  int   mismatches;
  int   results_due;

  ucs2u8_in_if  units_ch ();
  ucs2u8_out_if results_ch ();

  ucs2_utf8_transcoder dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .units    (units_ch),
    .results  (results_ch)
  );

  ucs2u8_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .units       (units_ch),
    .results     (results_ch),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #8_000_000;
    $display("%0t: timeout", $time);
    $display("== FAIL ==");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic int in_gap();
    if (no_gaps || $urandom_range(0, 1) == 0) return 0;
    return gap_len();
  endfunction

  function automatic logic [7:0] high_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly a proper 10xxxxxx byte, sometimes any nonzero byte
  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(1, 255));
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  // result side: ready drops for random stretches unless gaps are off
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall--;
      if (out_stall == 0) results_ch.ready <= 1'b1;
    end else if (!no_gaps && $urandom_range(0, 4) == 0) begin
      out_stall = gap_len();
      results_ch.ready <= 1'b0;
    end else begin
      results_ch.ready <= 1'b1;
    end
  end

  // called at a falling edge, returns at a falling edge; valid stays high
  // into the next word when no gap is drawn
  task automatic send_word(input logic [15:0] w);
    int gap;
    units_ch.valid   <= 1'b1;
    units_ch.in_unit <= w;
    @(posedge clk);
    while (!units_ch.ready) @(posedge clk);
    @(negedge clk);
    gap = in_gap();
    if (gap > 0) begin
      units_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // block goes quiet: all predicted words out, and the wait goes on beyond that
  // since a lead byte may still be in flight without producing anything
  task automatic drain();
    int guard;
    guard = 0;
    units_ch.valid <= 1'b0;
    while (results_due != 0 && guard < DRAIN_GUARD) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
  endtask

  task automatic write_direction(input dir_t d);
    cfg_we   <= 1'b1;
    cfg_data <= d;
    @(negedge clk);
    cfg_we   <= 1'b0;
    @(negedge clk);
  endtask

  task automatic encode_burst(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 6) send_word(16'h0000);
      else if (r < 30) send_word(16'($urandom_range(1, 16'h007F)));
      else if (r < 55) send_word(16'($urandom_range(16'h0080, 16'h07FF)));
      else if (r < 80) send_word(16'($urandom_range(16'h0800, 16'hFFFF)));
      else send_word(16'($urandom));
    end
  endtask

  // mostly whole characters with random high bytes, the rest cut-off
  // characters, terminators and raw noise
  task automatic decode_burst(input int n);
    int         sent;
    int         r;
    logic [7:0] lead;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_word({high_byte(), 8'h00});
        sent += 1;
      end else if (r < 12) begin
        // string ends inside a character
        lead = 8'($urandom_range(8'h80, 8'hFF));
        send_word({high_byte(), lead});
        sent += 1;
        if (lead >= 8'hE0 && $urandom_range(0, 1) == 1) begin
          send_word({high_byte(), cont_byte()});
          sent += 1;
        end
        send_word({high_byte(), 8'h00});
        sent += 1;
      end else if (r < 40) begin
        send_word({high_byte(), 8'($urandom_range(1, 8'h7F))});
        sent += 1;
      end else if (r < 70) begin
        if ($urandom_range(0, 9) == 0) lead = 8'($urandom_range(8'h80, 8'hBF));
        else lead = 8'($urandom_range(8'hC0, 8'hDF));
        send_word({high_byte(), lead});
        send_word({high_byte(), cont_byte()});
        sent += 2;
      end else if (r < 90) begin
        send_word({high_byte(), 8'($urandom_range(8'hE0, 8'hFF))});
        send_word({high_byte(), cont_byte()});
        send_word({high_byte(), cont_byte()});
        sent += 3;
      end else begin
        send_word(16'($urandom));
        sent += 1;
      end
    end
  endtask

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_data         = 1'b0;
    no_gaps          = 1'b0;
    out_stall        = 0;
    units_ch.valid   = 1'b0;
    units_ch.in_unit = '0;
    results_ch.ready = 1'b0;

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed encode, range edges and the empty string
    write_direction(DIR_ENCODE);
    foreach (ENC_CASES[i]) send_word(ENC_CASES[i]);
    drain();

    // directed decode
    write_direction(DIR_DECODE);
    foreach (DEC_CASES[i]) send_word(DEC_CASES[i]);
    drain();

    // register write while a three-byte character is half gathered drops it
    send_word(16'h00E2);
    send_word(16'h0082);
    drain();
    write_direction(DIR_DECODE);
    send_word(16'h0041);
    send_word(16'h0000);
    drain();

    // random bursts, directions 0 1 1 0 0 1 so some writes repeat the value
    for (int p = 0; p < 6; p++) begin
      write_direction(dir_t'(((p + 1) / 2) % 2));
      no_gaps = (p == 3);
      if (((p + 1) / 2) % 2 == 1) decode_burst(BURST_WORDS);
      else encode_burst(BURST_WORDS);
      drain();
    end
    no_gaps = 1'b0;

    drain();
    if (mismatches == 0 && results_due == 0) begin
      $display("== PASS ==");
    end else begin
      if (results_due != 0)
        $display("%0t: %0d result words never arrived", $time, results_due);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
